// ===== src/ffba_pkg.sv =====
// Shared widths, codes and result type for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    localparam int NUM_BLOCKS_DEF = 32;

    localparam int ENTRY_W = 5;
    localparam int SIZE_W  = 16;
    localparam int BIDX_W  = 5;
    localparam int BIU_W   = 6;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select is paddr[2]
    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    localparam logic CMD_LOAD = 1'b0;

    typedef struct packed {
        logic              granted;
        logic [BIDX_W-1:0] block_index;
        logic [SIZE_W-1:0] leftover;
    } res_t;

endpackage

`default_nettype wire

// ===== src/first_fit_block_allocator_unit.sv =====
// First-fit block allocator: stream command port, APB register, result stream.
//
// Usage: commands arrive as beats on s_*. s_tuser = 0 loads s_tdata's size into
// the entry given by s_tdata (and marks it free); s_tuser = 1 asks for a block
// of at least that size. Each command yields exactly one beat on m_*: m_tuser
// is the grant flag, m_tdata carries the block index and the leftover space.
// blocks_in_use (APB offset 0x0) sets how many entries from index 0 are
// searched, capped at NUM_BLOCKS; write it only while no command is in flight.
// A load is written on accept and its result is handed over from the done state. A request
// reads one size RAM entry per cycle, from index 0 up to the search limit, and stops
// early when a block fits. One command is in work at once.
// Reset clears every used mark and blocks_in_use; the size table is not
// cleared and must be loaded before it is searched.
// A finished result sits in the output register until m_tready; the next
// command is taken meanwhile, but its result waits for the register to free.
`default_nettype none

module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    // APB
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [APB_ADDR_W-1:0]  paddr,
    input  wire [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // command stream
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [IN_TDATA_W-1:0]  s_tdata,   // [4:0] entry_index, [20:5] size_value, rest 0
    input  wire                   s_tuser,   // [0] cmd
    // result stream
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // [4:0] block_index, [20:5] leftover, rest 0
    output logic                  m_tuser    // [0] granted
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic [BIU_W-1:0] biu_reg, biu_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg;

    logic              cfg_wr;
    logic              out_free;
    logic              res_load;
    res_t              res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;

    always_comb
    begin
        pready   = 1'b1;
        cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCKS_IN_USE);
        biu_next = cfg_wr ? pwdata[BIU_W-1:0] : biu_reg;
        prdata   = (paddr[2] == REG_BLOCKS_IN_USE) ? APB_DATA_W'(biu_reg) : '0;

        out_free       = !out_valid_reg || m_tready;
        out_valid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        m_tvalid = out_valid_reg;
        m_tuser  = out_res_reg.granted;
        m_tdata  = OUT_TDATA_W'({out_res_reg.leftover, out_res_reg.block_index});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            biu_reg       <= biu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    ffba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser),
        .in_entry      (s_tdata[ENTRY_W-1:0]),
        .in_size       (s_tdata[ENTRY_W +: SIZE_W]),
        .blocks_in_use (biu_reg),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    ffba_size_ram #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // a command in work blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one in work");

    // a new result only comes out of the finishing cycle of a command
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat without a command in work");
`endif

endmodule

`default_nettype wire

// ===== src/ffba_size_ram.sv =====
// Block size table: one write port, one registered read port.
`default_nettype none

module ffba_size_ram
    import ffba_pkg::*;
#(
    parameter int DEPTH  = NUM_BLOCKS_DEF,
    parameter int ADDR_W = 5
)
(
    input  wire              clk,
    input  wire              we,
    input  wire [ADDR_W-1:0] waddr,
    input  wire [SIZE_W-1:0] wdata,
    input  wire [ADDR_W-1:0] raddr,
    output logic [SIZE_W-1:0] rdata
);

    logic [SIZE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/ffba_ctrl.sv =====
// Command sequencer: table loads, first-fit scan over the size RAM, used marks.
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire               in_cmd,
    input  wire [ENTRY_W-1:0] in_entry,
    input  wire [SIZE_W-1:0]  in_size,
    input  wire [BIU_W-1:0]   blocks_in_use,
    input  wire               out_free,
    output logic              res_load,
    output res_t              res,
    output logic              ram_we,
    output logic [IDX_W-1:0]  ram_waddr,
    output logic [SIZE_W-1:0] ram_wdata,
    output logic [IDX_W-1:0]  ram_raddr,
    input  wire [SIZE_W-1:0]  ram_rdata
);

    localparam int CMP_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [CNT_W-1:0]      limit_reg, limit_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    res_t                  res_reg, res_next;
    logic [NUM_BLOCKS-1:0] used_reg, used_next;

    logic             accept;
    logic             entry_ok;
    logic [CMP_W-1:0] biu_ext;
    logic [CNT_W-1:0] limit;
    logic             hit;
    logic             last;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        accept   = in_valid && in_ready;
        entry_ok = CMP_W'(in_entry) < CMP_W'(NUM_BLOCKS);
        biu_ext  = CMP_W'(blocks_in_use);
        limit    = (biu_ext > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_ext);
        hit      = !used_reg[idx_reg] && (ram_rdata >= size_reg);
        last     = (CNT_W'(idx_reg) + CNT_W'(1)) == limit_reg;

        state_next = state_reg;
        size_next  = size_reg;
        limit_next = limit_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        used_next  = used_reg;
        ram_we     = 1'b0;
        ram_waddr  = IDX_W'(in_entry);
        ram_wdata  = in_size;
        ram_raddr  = '0;
        res_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        ram_we   = entry_ok;
                        res_next = '{granted: 1'b0, block_index: in_entry, leftover: '0};
                        if (entry_ok)
                        begin
                            used_next[IDX_W'(in_entry)] = 1'b0;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // entry 0 is read on this edge, data is ready in the first scan cycle
                        size_next  = in_size;
                        limit_next = limit;
                        idx_next   = '0;
                        res_next   = '0;
                        state_next = (limit == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    used_next[idx_reg] = 1'b1;
                    res_next = '{granted: 1'b1, block_index: BIDX_W'(idx_reg),
                                 leftover: ram_rdata - size_reg};
                    state_next = S_DONE;
                end
                else if (last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + IDX_W'(1);
                    ram_raddr = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                res_load = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking stream/APB testbench for the first-fit block allocator.
`default_nettype none

module tb_top;
    import ffba_pkg::*;

    localparam logic CMD_ALLOC   = 1'b1;
    localparam int   NBLK        = NUM_BLOCKS_DEF;
    localparam int   HOLD_CYCLES = 400;
    localparam int   PHASE_ITEMS = 100;
    localparam int   N_PHASE     = 9;
    localparam int   N_DIR       = 21;
    localparam int   TAIL_CYCLES = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [4:0] entry_index, [20:5] size_value, rest 0
    logic                   s_tuser;   // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [4:0] block_index, [20:5] leftover, rest 0
    logic                   m_tuser;   // [0] granted

    first_fit_block_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        cmd;
        logic [4:0]  entry;
        logic [15:0] value;      // size, or blocks_in_use on a config row
        bit          typed;
        logic        w_granted;
        logic [4:0]  w_index;
        logic [15:0] w_left;
    } dir_row_t;

    // allocator state as the testbench sees it
    logic [SIZE_W-1:0] blk_size [NBLK];
    logic              blk_used [NBLK];
    logic [BIU_W-1:0]  scan_count;

    res_t     grant_q [$];
    res_t     mon_want;
    dir_row_t dir_tab [N_DIR];
    int       n_err;
    int       burst_left;
    bit       hold_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic res_t first_fit_predict(input logic cmd, input logic [4:0] entry,
                                               input logic [15:0] size);
        res_t r;
        int   lim;
        r = '0;
        if (cmd == CMD_LOAD)
        begin
            blk_size[entry] = size;
            blk_used[entry] = 1'b0;
            r.block_index   = entry;
            return r;
        end
        lim = (scan_count > NBLK) ? NBLK : int'(scan_count);
        for (int k = 0; k < lim; k++)
        begin
            if (!blk_used[k] && blk_size[k] >= size)
            begin
                blk_used[k]   = 1'b1;
                r.granted     = 1'b1;
                r.block_index = BIDX_W'(k);
                r.leftover    = blk_size[k] - size;
                return r;
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_cmd(input logic cmd, input logic [4:0] entry, input logic [15:0] size,
                            input bit typed, input res_t want);
        res_t pred;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, size, entry};
        do @(posedge clk); while (!s_tready);
        pred = first_fit_predict(cmd, entry, size);
        grant_q.push_back(typed ? want : pred);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (grant_q.size() != 0) @(negedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_blocks_in_use(input logic [BIU_W-1:0] val);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_ADDR_W-1:0] addr;
        drain();
        addr = {REG_BLOCKS_IN_USE, 2'b00};
        apb_xfer(1'b1, addr, APB_DATA_W'(val), rd);
        scan_count = val;
        apb_xfer(1'b0, addr, '0, rd);
        if (rd !== APB_DATA_W'(val))
        begin
            $display("%0t: blocks_in_use readback expected %0d actual %0d", $realtime, val, rd);
            n_err++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, granted %0b index %0d left %0d",
                         $realtime, m_tuser, m_tdata[4:0], m_tdata[20:5]);
                n_err++;
            end
            else
            begin
                mon_want = grant_q.pop_front();
                if (m_tuser !== mon_want.granted)
                begin
                    $display("%0t: granted expected %0b actual %0b",
                             $realtime, mon_want.granted, m_tuser);
                    n_err++;
                end
                if (m_tdata[4:0] !== mon_want.block_index)
                begin
                    $display("%0t: block_index expected %0d actual %0d",
                             $realtime, mon_want.block_index, m_tdata[4:0]);
                    n_err++;
                end
                if (m_tdata[20:5] !== mon_want.leftover)
                begin
                    $display("%0t: leftover expected %0d actual %0d",
                             $realtime, mon_want.leftover, m_tdata[20:5]);
                    n_err++;
                end
            end
        end
    end

    // result side: segments of varying backpressure, plus one long hold-off on request
    initial
    begin : rx_proc
        int seg_left;
        int mode;
        int cyc;
        m_tready = 1'b0;
        seg_left = 0;
        mode     = 0;
        cyc      = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    initial
    begin : main_proc
        int          order [NBLK];
        int          phase_biu [N_PHASE];
        int          j;
        int          t;
        int          k;
        logic [15:0] sz;
        logic [4:0]  ent;
        res_t        want;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tuser    = CMD_LOAD;
        s_tdata    = '0;
        n_err      = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        scan_count = '0;
        for (int i = 0; i < NBLK; i++)
        begin
            blk_size[i] = '0;
            blk_used[i] = 1'b0;
        end

        // after reset nothing is searched; entries are loaded before any scan reaches them
        dir_tab = '{
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h0000, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd0,  16'hFFFF, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd1,  16'h0000, 1'b1, 1'b0, 5'd1,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd2,  16'd100,  1'b1, 1'b0, 5'd2,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd31, 16'h1234, 1'b1, 1'b0, 5'd31, 16'h0000},
            '{ROW_CFG,  CMD_LOAD,  5'd0,  16'd3,    1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'hFFFF, 1'b1, 1'b1, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd31, 16'h0000, 1'b1, 1'b1, 5'd1,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd7,  16'd50,   1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h0000, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'hFFFF, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd0,  16'hFFFF, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h0001, 1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd1,  16'h0000, 1'b1, 1'b0, 5'd1,  16'h0000},
            '{ROW_CFG,  CMD_LOAD,  5'd0,  16'd63,   1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h0000, 1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_CFG,  CMD_LOAD,  5'd0,  16'd1,    1'b0, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h0000, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_LOAD,  5'd0,  16'h8000, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h8001, 1'b1, 1'b0, 5'd0,  16'h0000},
            '{ROW_BEAT, CMD_ALLOC, 5'd0,  16'h8000, 1'b1, 1'b1, 5'd0,  16'h0000}
        };
        // -1 picks a random count, over-range values check saturation
        phase_biu = '{63, 32, 0, 1, -1, 32, -1, 2, 33};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                set_blocks_in_use(BIU_W'(dir_tab[i].value));
            else
            begin
                want = {dir_tab[i].w_granted, dir_tab[i].w_index, dir_tab[i].w_left};
                send_cmd(dir_tab[i].cmd, dir_tab[i].entry, dir_tab[i].value,
                         dir_tab[i].typed, want);
            end
        end

        // load every entry once, in shuffled order, so any scan count is legal afterwards
        for (int i = 0; i < NBLK; i++)
            order[i] = i;
        for (int i = NBLK - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < NBLK; i++)
            send_cmd(CMD_LOAD, 5'(order[i]), 16'($urandom), 1'b0, '0);

        for (int p = 0; p < N_PHASE; p++)
        begin
            set_blocks_in_use((phase_biu[p] < 0) ? BIU_W'($urandom_range(0, 63))
                                                 : BIU_W'(phase_biu[p]));
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 50)
                    drain();
                if ($urandom_range(0, 99) < 40)
                begin
                    ent = 5'($urandom_range(0, NBLK - 1));
                    case ($urandom_range(0, 7))
                        0: sz = 16'h0000;
                        1: sz = 16'hFFFF;
                        2: sz = 16'($urandom_range(0, 255));
                        default: sz = 16'($urandom);
                    endcase
                    send_cmd(CMD_LOAD, ent, sz, 1'b0, '0);
                end
                else
                begin
                    // request sizes mostly sit around existing block sizes
                    k = $urandom_range(0, NBLK - 1);
                    case ($urandom_range(0, 4))
                        0: sz = 16'($urandom);
                        1: sz = blk_size[k];
                        2: sz = blk_size[k] >> $urandom_range(1, 4);
                        3: sz = (blk_size[k] == 16'hFFFF) ? blk_size[k] : blk_size[k] + 16'd1;
                        default: sz = 16'($urandom_range(0, 255));
                    endcase
                    send_cmd(CMD_ALLOC, 5'($urandom), sz, 1'b0, '0);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (n_err == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
